FILE: hw/rtl/mtwa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtwa_pkg: shared types and constants of the pressure conditioner
// Pressure format, weight register map, arithmetic widths and sequencer states.
// ----------------------------------------------------------------------------
package mtwa_pkg;

	// pressure: unsigned Pa with 4 fraction bits
	localparam int PRESS_W = 21;
	localparam logic [PRESS_W-1:0] HELD_RESET = 21'd304;

	// weight registers
	localparam int WGT_W     = 8;
	localparam int NUM_WGT   = 4;
	localparam int CFG_IDX_W = 2;

	typedef enum logic [CFG_IDX_W-1:0] {
		REG_WEIGHT_NEWEST = 2'd0,
		REG_WEIGHT_SECOND = 2'd1,
		REG_WEIGHT_THIRD  = 2'd2,
		REG_WEIGHT_OLDEST = 2'd3
	} reg_idx_t;

	localparam logic [WGT_W-1:0] WEIGHT_NEWEST_RESET = 8'd50;
	localparam logic [WGT_W-1:0] WEIGHT_SECOND_RESET = 8'd25;
	localparam logic [WGT_W-1:0] WEIGHT_THIRD_RESET  = 8'd15;
	localparam logic [WGT_W-1:0] WEIGHT_OLDEST_RESET = 8'd10;

	// at most four taps carry weight: sum below 4 * 255 * 2^21
	localparam int ACC_W  = 31;
	localparam int DEN_W  = 10;
	localparam int STEP_W = 5;

	// sequencer states
	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MED,
		ST_MAC,
		ST_DIV,
		ST_DONE
	} state_t;

endpackage

FILE: hw/rtl/mtwa_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtwa channel interfaces
// Sample input channel, result output channel and weight write channel.
// ----------------------------------------------------------------------------

// sample item: error flag and raw pressure
interface mtwa_sample_if;
	logic                        valid;
	logic                        ready;
	logic                        sensor_error;
	logic [mtwa_pkg::PRESS_W-1:0] pressure_sample;

	modport source (output valid, output sensor_error, output pressure_sample, input ready);
	modport sink   (input valid, input sensor_error, input pressure_sample, output ready);
endinterface

// result item: filtered pressure and error copy
interface mtwa_result_if;
	logic                        valid;
	logic                        ready;
	logic [mtwa_pkg::PRESS_W-1:0] filtered_pressure;
	logic                        error_flag;

	modport source (output valid, output filtered_pressure, output error_flag, input ready);
	modport sink   (input valid, input filtered_pressure, input error_flag, output ready);
endinterface

// weight register writes
interface mtwa_cfg_if;
	logic                          valid;
	logic                          ready;
	logic [mtwa_pkg::CFG_IDX_W-1:0] index;
	logic [mtwa_pkg::WGT_W-1:0]     data;

	modport source (output valid, output index, output data, input ready);
	modport sink   (input valid, input index, input data, output ready);
endinterface

FILE: hw/rtl/median_then_weighted_average_filter.sv
`timescale 1ns / 1ps
// Sequence: a good item passes through the median search, the multiply-accumulate over the
// taps and, unless the weights sum to zero, the division steps; the median search uses one shared comparator.
// An item with the error flag set goes straight to the output. One item at a time; a finished result
// waits in the output register while the next item is accepted.
// Reset: windows clear to zero, held output goes to 19.0 Pa, weights to 50/25/15/10.
// ----------------------------------------------------------------------------
// median_then_weighted_average_filter
// Median of the newest samples, then weighted average of the newest medians,
// on one comparator, one multiply-accumulate and one restoring divider step.
// ----------------------------------------------------------------------------
module median_then_weighted_average_filter #(
	parameter int MEDIAN_WINDOW = 5,
	parameter int AVERAGE_TAPS  = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	mtwa_sample_if.sink          sample_ch,
	mtwa_result_if.source        result_ch,
	mtwa_cfg_if.sink             cfg_ch
);

	localparam int PW     = mtwa_pkg::PRESS_W;
	localparam int MED_K  = MEDIAN_WINDOW / 2;
	localparam int IDX_W  = $clog2(MEDIAN_WINDOW);
	localparam int CNT_W  = $clog2(MEDIAN_WINDOW + 1);
	localparam int TAP_W  = $clog2(AVERAGE_TAPS);
	localparam int AW     = mtwa_pkg::ACC_W;
	localparam int DW     = mtwa_pkg::DEN_W;
	localparam int SW     = mtwa_pkg::STEP_W;
	localparam int WW     = mtwa_pkg::WGT_W;

	mtwa_pkg::state_t state_q, state_d;

	// filter state
	logic [PW-1:0] win_q  [MEDIAN_WINDOW];
	logic [PW-1:0] hist_q [AVERAGE_TAPS];
	logic [PW-1:0] held_q;
	logic          err_q;
	logic [WW-1:0] wgt_q  [mtwa_pkg::NUM_WGT];

	// median search
	logic [PW-1:0]    ring_q [MEDIAN_WINDOW];
	logic [PW-1:0]    cand_q;
	logic [IDX_W-1:0] j_q;
	logic [CNT_W-1:0] less_q, leq_q;

	// multiply-accumulate and divider
	logic [TAP_W-1:0] k_q;
	logic [AW-1:0]    acc_q;
	logic [DW-1:0]    den_q;
	logic [DW-1:0]    rem_q;
	logic [PW-1:0]    lo_q;
	logic [SW-1:0]    step_q;

	// output register
	logic          out_valid_q;
	logic [PW-1:0] out_press_q;
	logic          out_err_q;

	// control
	logic in_rdy, accept, out_free, out_load;

	// combinational datapath
	logic             cmp_lt, cmp_le, last_cmp, found;
	logic [CNT_W-1:0] less_sum, leq_sum;
	logic [WW-1:0]    w_sel;
	logic [WW+PW-1:0] product;
	logic [AW-1:0]    acc_sum;
	logic [DW-1:0]    den_sum;
	logic             last_tap;
	logic [DW:0]      rem_sh;
	logic             div_ge;
	logic [DW-1:0]    rem_nx;
	logic             last_step;

	// shared comparator: window entry against candidate
	always_comb begin
		cmp_lt   = ring_q[0] < cand_q;
		cmp_le   = ring_q[0] <= cand_q;
		less_sum = less_q + CNT_W'(cmp_lt);
		leq_sum  = leq_q + CNT_W'(cmp_le);
		last_cmp = (j_q == IDX_W'(MEDIAN_WINDOW - 1));
		found    = last_cmp && (less_sum <= CNT_W'(MED_K)) && (leq_sum > CNT_W'(MED_K));
	end

	// weight of the current tap, zero past the fourth
	always_comb begin
		w_sel = '0;
		for (int m = 0; m < mtwa_pkg::NUM_WGT; m++) begin
			if (int'(k_q) == m) begin
				w_sel = wgt_q[m];
			end
		end
	end

	// multiply-accumulate
	always_comb begin
		product  = w_sel * hist_q[k_q];
		acc_sum  = acc_q + AW'(product);
		den_sum  = den_q + DW'(w_sel);
		last_tap = (k_q == TAP_W'(AVERAGE_TAPS - 1));
	end

	// one restoring division step
	always_comb begin
		rem_sh    = {rem_q, lo_q[PW-1]};
		div_ge    = rem_sh >= {1'b0, den_q};
		rem_nx    = div_ge ? DW'(rem_sh - {1'b0, den_q}) : DW'(rem_sh);
		last_step = (step_q == SW'(PW - 1));
	end

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			mtwa_pkg::ST_IDLE: begin
				if (accept) begin
					state_d = sample_ch.sensor_error ? mtwa_pkg::ST_DONE : mtwa_pkg::ST_MED;
				end
			end
			mtwa_pkg::ST_MED: begin
				if (found) begin
					state_d = mtwa_pkg::ST_MAC;
				end
			end
			mtwa_pkg::ST_MAC: begin
				if (last_tap) begin
					state_d = (den_sum == '0) ? mtwa_pkg::ST_DONE : mtwa_pkg::ST_DIV;
				end
			end
			mtwa_pkg::ST_DIV: begin
				if (last_step) begin
					state_d = mtwa_pkg::ST_DONE;
				end
			end
			mtwa_pkg::ST_DONE: begin
				if (out_free) begin
					state_d = mtwa_pkg::ST_IDLE;
				end
			end
			default: state_d = mtwa_pkg::ST_IDLE;
		endcase
	end

	// handshake outputs
	always_comb begin
		in_rdy   = 1'b0;
		out_load = 1'b0;
		out_free = !out_valid_q || result_ch.ready;
		case (state_q)
			mtwa_pkg::ST_IDLE: in_rdy   = 1'b1;
			mtwa_pkg::ST_DONE: out_load = out_free;
			default: begin
				in_rdy   = 1'b0;
				out_load = 1'b0;
			end
		endcase
		accept = sample_ch.valid && in_rdy;
	end

	assign sample_ch.ready            = in_rdy;
	assign cfg_ch.ready               = 1'b1;
	assign result_ch.valid            = out_valid_q;
	assign result_ch.filtered_pressure = out_press_q;
	assign result_ch.error_flag       = out_err_q;

	// control and filter state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= mtwa_pkg::ST_IDLE;
			out_valid_q <= 1'b0;
			held_q      <= mtwa_pkg::HELD_RESET;
			err_q       <= 1'b0;
			for (int m = 0; m < MEDIAN_WINDOW; m++) begin
				win_q[m] <= '0;
			end
			for (int m = 0; m < AVERAGE_TAPS; m++) begin
				hist_q[m] <= '0;
			end
			wgt_q[mtwa_pkg::REG_WEIGHT_NEWEST] <= mtwa_pkg::WEIGHT_NEWEST_RESET;
			wgt_q[mtwa_pkg::REG_WEIGHT_SECOND] <= mtwa_pkg::WEIGHT_SECOND_RESET;
			wgt_q[mtwa_pkg::REG_WEIGHT_THIRD]  <= mtwa_pkg::WEIGHT_THIRD_RESET;
			wgt_q[mtwa_pkg::REG_WEIGHT_OLDEST] <= mtwa_pkg::WEIGHT_OLDEST_RESET;
		end else begin
			state_q <= state_d;

			// weight writes
			if (cfg_ch.valid) begin
				wgt_q[cfg_ch.index] <= cfg_ch.data;
			end

			// item accepted: record error, shift good sample into the window
			if (accept) begin
				err_q <= sample_ch.sensor_error;
				if (!sample_ch.sensor_error) begin
					win_q[0] <= sample_ch.pressure_sample;
					for (int m = 1; m < MEDIAN_WINDOW; m++) begin
						win_q[m] <= win_q[m-1];
					end
				end
			end

			// median found: shift into history
			if (state_q == mtwa_pkg::ST_MED && found) begin
				hist_q[0] <= cand_q;
				for (int m = 1; m < AVERAGE_TAPS; m++) begin
					hist_q[m] <= hist_q[m-1];
				end
			end

			// zero weight sum holds zero
			if (state_q == mtwa_pkg::ST_MAC && last_tap && den_sum == '0) begin
				held_q <= '0;
			end

			// quotient complete
			if (state_q == mtwa_pkg::ST_DIV && last_step) begin
				held_q <= {lo_q[PW-2:0], div_ge};
			end

			// output register
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (result_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// working registers of the sequencer
	always_ff @(posedge clk) begin
		if (out_load) begin
			out_press_q <= held_q;
			out_err_q   <= err_q;
		end
		case (state_q)
			mtwa_pkg::ST_IDLE: begin
				// copy of the new window, first candidate is the newest sample
				ring_q[0] <= sample_ch.pressure_sample;
				for (int m = 1; m < MEDIAN_WINDOW; m++) begin
					ring_q[m] <= win_q[m-1];
				end
				cand_q <= sample_ch.pressure_sample;
				j_q    <= '0;
				less_q <= '0;
				leq_q  <= '0;
			end
			mtwa_pkg::ST_MED: begin
				if (!last_cmp) begin
					// count entries below and not above the candidate
					for (int m = 0; m < MEDIAN_WINDOW; m++) begin
						ring_q[m] <= ring_q[(m + 1) % MEDIAN_WINDOW];
					end
					j_q    <= j_q + IDX_W'(1);
					less_q <= less_sum;
					leq_q  <= leq_sum;
				end else begin
					// next candidate: rotate one past the start
					for (int m = 0; m < MEDIAN_WINDOW; m++) begin
						ring_q[m] <= ring_q[(m + 2) % MEDIAN_WINDOW];
					end
					cand_q <= ring_q[2];
					j_q    <= '0;
					less_q <= '0;
					leq_q  <= '0;
				end
				k_q   <= '0;
				acc_q <= '0;
				den_q <= '0;
			end
			mtwa_pkg::ST_MAC: begin
				k_q   <= k_q + TAP_W'(1);
				acc_q <= acc_sum;
				den_q <= den_sum;
				// high part of the sum is below the divisor
				rem_q  <= acc_sum[AW-1:PW];
				lo_q   <= acc_sum[PW-1:0];
				step_q <= '0;
			end
			mtwa_pkg::ST_DIV: begin
				rem_q  <= rem_nx;
				lo_q   <= {lo_q[PW-2:0], div_ge};
				step_q <= step_q + SW'(1);
			end
			default: begin
				step_q <= '0;
			end
		endcase
	end

endmodule

FILE: tb/mtwa_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mtwa_result_checker: result checker of the pressure conditioner
// Watches the sample, result and weight channels, keeps its own copy of the
// median window, median history, held output and weights, predicts each
// result and compares it field by field with what the block returns.
// ----------------------------------------------------------------------------
module mtwa_result_checker (
	input  logic    clk,
	input  logic    arst_n,
	mtwa_sample_if  sample_ch,
	mtwa_result_if  result_ch,
	mtwa_cfg_if     cfg_ch,
	output int      fail_count,
	output int      pending_results,
	output int      results_checked
);

	localparam int MEDIAN_WINDOW = 5;
	localparam int AVERAGE_TAPS  = 4;

	typedef struct packed {
		logic [mtwa_pkg::PRESS_W-1:0] pressure;
		logic                         error;
	} filter_result_t;

	logic [mtwa_pkg::PRESS_W-1:0] sample_window  [MEDIAN_WINDOW];
	logic [mtwa_pkg::PRESS_W-1:0] median_history [AVERAGE_TAPS];
	logic [mtwa_pkg::PRESS_W-1:0] held_pressure;
	logic [mtwa_pkg::WGT_W-1:0]   weight         [mtwa_pkg::NUM_WGT];

	filter_result_t expected_results[$];
	int fails;
	int checked;

	// middle element of the sorted sample window
	function automatic logic [mtwa_pkg::PRESS_W-1:0] window_median();
		logic [mtwa_pkg::PRESS_W-1:0] sorted [MEDIAN_WINDOW];
		logic [mtwa_pkg::PRESS_W-1:0] key;
		int i;
		int j;
		for (i = 0; i < MEDIAN_WINDOW; i++)
			sorted[i] = sample_window[i];
		for (i = 1; i < MEDIAN_WINDOW; i++) begin
			key = sorted[i];
			j = i - 1;
			while (j >= 0 && sorted[j] > key) begin
				sorted[j + 1] = sorted[j];
				j--;
			end
			sorted[j + 1] = key;
		end
		return sorted[MEDIAN_WINDOW / 2];
	endfunction

	// weighted mean of the median history, zero when the weights sum to zero
	function automatic logic [mtwa_pkg::PRESS_W-1:0] history_average();
		logic [63:0] num;
		logic [63:0] den;
		logic [63:0] w;
		int i;
		num = '0;
		den = '0;
		for (i = 0; i < AVERAGE_TAPS; i++) begin
			w = (i < mtwa_pkg::NUM_WGT) ? 64'(weight[i]) : 64'd0;
			num += w * 64'(median_history[i]);
			den += w;
		end
		if (den == 0)
			return '0;
		return mtwa_pkg::PRESS_W'(num / den);
	endfunction

	// advance the filter by one sample item and give the result it causes
	function automatic filter_result_t filter_sample(input logic err,
			input logic [mtwa_pkg::PRESS_W-1:0] sample);
		filter_result_t r;
		int i;
		if (!err) begin
			for (i = MEDIAN_WINDOW - 1; i > 0; i--)
				sample_window[i] = sample_window[i - 1];
			sample_window[0] = sample;
			for (i = AVERAGE_TAPS - 1; i > 0; i--)
				median_history[i] = median_history[i - 1];
			median_history[0] = window_median();
			held_pressure = history_average();
		end
		r.pressure = held_pressure;
		r.error    = err;
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		filter_result_t want;
		if (!arst_n) begin
			for (int i = 0; i < MEDIAN_WINDOW; i++)
				sample_window[i] = '0;
			for (int i = 0; i < AVERAGE_TAPS; i++)
				median_history[i] = '0;
			held_pressure = mtwa_pkg::HELD_RESET;
			weight[mtwa_pkg::REG_WEIGHT_NEWEST] = mtwa_pkg::WEIGHT_NEWEST_RESET;
			weight[mtwa_pkg::REG_WEIGHT_SECOND] = mtwa_pkg::WEIGHT_SECOND_RESET;
			weight[mtwa_pkg::REG_WEIGHT_THIRD]  = mtwa_pkg::WEIGHT_THIRD_RESET;
			weight[mtwa_pkg::REG_WEIGHT_OLDEST] = mtwa_pkg::WEIGHT_OLDEST_RESET;
			expected_results.delete();
			fails = 0;
			checked = 0;
		end else begin
			// weight writes
			if (cfg_ch.valid && cfg_ch.ready && cfg_ch.index < mtwa_pkg::NUM_WGT)
				weight[cfg_ch.index] = cfg_ch.data;

			// compare a returned item with the oldest prediction
			if (result_ch.valid && result_ch.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t ns: result with none expected: pressure %0d error %0d",
						$time, result_ch.filtered_pressure, result_ch.error_flag);
					fails++;
				end else begin
					want = expected_results.pop_front();
					checked++;
					if (result_ch.filtered_pressure !== want.pressure ||
							result_ch.error_flag !== want.error) begin
						fails++;
						if (result_ch.filtered_pressure !== want.pressure)
							$display("%0t ns: filtered_pressure expected %0d got %0d",
								$time, want.pressure, result_ch.filtered_pressure);
						if (result_ch.error_flag !== want.error)
							$display("%0t ns: error_flag expected %0d got %0d",
								$time, want.error, result_ch.error_flag);
					end
				end
			end

			// predict each accepted sample item
			if (sample_ch.valid && sample_ch.ready)
				expected_results.push_back(filter_sample(sample_ch.sensor_error,
					sample_ch.pressure_sample));
		end
		fail_count      <= fails;
		pending_results <= expected_results.size();
		results_checked <= checked;
	end

endmodule

FILE: tb/median_then_weighted_average_filter_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// median_then_weighted_average_filter_test: testbench of the pressure conditioner
// Directed samples at the field extremes and around sensor errors, then random
// sample streams under several weight settings, including all-zero and
// all-maximum weights, with random idling on both sides, a long output hold
// and a full drain. A separate checker predicts and compares every result.
// ----------------------------------------------------------------------------
module median_then_weighted_average_filter_test;

	localparam logic [mtwa_pkg::PRESS_W-1:0] PRESS_MAX = '1;
	localparam int WATCHDOG_LIMIT = 4000;
	localparam int HOLD_CYCLES    = 400;
	localparam int SETTLE_CYCLES  = 60;

	typedef enum {
		GAPS_NONE,
		GAPS_SENDER,
		GAPS_RECEIVER,
		GAPS_BOTH
	} gap_mode_t;

	logic clk;
	logic arst_n;

	mtwa_sample_if sample_ch ();
	mtwa_result_if result_ch ();
	mtwa_cfg_if    cfg_ch ();

	int fail_count;
	int pending_results;
	int results_checked;

	int src_idle_pct;
	int sink_stall_pct;
	int hold_requests;
	int long_holds;
	int items_sent;
	int weight_settings;
	int idle_cycles;
	logic [mtwa_pkg::PRESS_W-1:0] level;

	median_then_weighted_average_filter u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.sample_ch (sample_ch),
		.result_ch (result_ch),
		.cfg_ch    (cfg_ch)
	);

	mtwa_result_checker u_checker (
		.clk             (clk),
		.arst_n          (arst_n),
		.sample_ch       (sample_ch),
		.result_ch       (result_ch),
		.cfg_ch          (cfg_ch),
		.fail_count      (fail_count),
		.pending_results (pending_results),
		.results_checked (results_checked)
	);

	// clock
	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// result receiver: random stalls, and a long hold on request
	initial begin
		result_ch.ready <= 1'b0;
		long_holds = 0;
		forever begin
			@(posedge clk);
			if (long_holds < hold_requests) begin
				result_ch.ready <= 1'b0;
				repeat (HOLD_CYCLES) @(posedge clk);
				long_holds++;
			end else begin
				result_ch.ready <= ($urandom_range(0, 99) >= sink_stall_pct);
			end
		end
	end

	// watchdog on cycles with no item moving on any channel
	always @(posedge clk) begin
		if (!arst_n || (sample_ch.valid && sample_ch.ready) ||
				(result_ch.valid && result_ch.ready) || (cfg_ch.valid && cfg_ch.ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("timeout after %0d cycles with no item moving", idle_cycles);
			$display("FAIL median_then_weighted_average_filter");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	task automatic set_gaps(input gap_mode_t mode);
		case (mode)
			GAPS_NONE:     begin src_idle_pct = 0;  sink_stall_pct = 0;  end
			GAPS_SENDER:   begin src_idle_pct = 49; sink_stall_pct = 0;  end
			GAPS_RECEIVER: begin src_idle_pct = 0;  sink_stall_pct = 49; end
			default:       begin src_idle_pct = 16; sink_stall_pct = 16; end
		endcase
	endtask

	task automatic write_weight(input mtwa_pkg::reg_idx_t idx,
			input logic [mtwa_pkg::WGT_W-1:0] value);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= value;
		@(posedge clk);
		while (!cfg_ch.ready) @(posedge clk);
		cfg_ch.valid <= 1'b0;
		@(posedge clk);
	endtask

	task automatic set_weights(input logic [mtwa_pkg::WGT_W-1:0] w0,
			input logic [mtwa_pkg::WGT_W-1:0] w1,
			input logic [mtwa_pkg::WGT_W-1:0] w2, input logic [mtwa_pkg::WGT_W-1:0] w3);
		write_weight(mtwa_pkg::REG_WEIGHT_NEWEST, w0);
		write_weight(mtwa_pkg::REG_WEIGHT_SECOND, w1);
		write_weight(mtwa_pkg::REG_WEIGHT_THIRD,  w2);
		write_weight(mtwa_pkg::REG_WEIGHT_OLDEST, w3);
		weight_settings++;
	endtask

	// offer one sample item, idling first as the sender mode asks
	task automatic offer_sample(input logic err, input logic [mtwa_pkg::PRESS_W-1:0] value);
		while ($urandom_range(0, 99) < src_idle_pct) begin
			sample_ch.valid <= 1'b0;
			@(posedge clk);
		end
		sample_ch.valid           <= 1'b1;
		sample_ch.sensor_error    <= err;
		sample_ch.pressure_sample <= value;
		@(posedge clk);
		while (!sample_ch.ready) @(posedge clk);
		items_sent++;
	endtask

	// stop offering and wait until every predicted result came back
	task automatic drain();
		sample_ch.valid <= 1'b0;
		@(posedge clk);
		while (pending_results != 0) @(posedge clk);
	endtask

	function automatic logic [mtwa_pkg::WGT_W-1:0] pick_weight();
		case ($urandom_range(0, 3))
			0:       return '0;
			1:       return '1;
			default: return mtwa_pkg::WGT_W'($urandom_range(0, 255));
		endcase
	endfunction

	// samples near a slowly moving level, with spikes and extremes
	function automatic logic [mtwa_pkg::PRESS_W-1:0] pick_pressure();
		case ($urandom_range(0, 9))
			0:       return PRESS_MAX;
			1:       return '0;
			2:       return mtwa_pkg::PRESS_W'($urandom_range(0, 255));
			3:       return PRESS_MAX - mtwa_pkg::PRESS_W'($urandom_range(0, 255));
			4, 5:    return mtwa_pkg::PRESS_W'($urandom_range(0, 32'h1FFFFF));
			default: return level + mtwa_pkg::PRESS_W'($urandom_range(0, 2047));
		endcase
	endfunction

	task automatic random_samples(input int count);
		repeat (count) begin
			if ($urandom_range(0, 15) == 0)
				level = mtwa_pkg::PRESS_W'($urandom_range(0, 32'h1FFFFF));
			offer_sample($urandom_range(0, 7) == 0, pick_pressure());
		end
	endtask

	// stimulus and verdict
	initial begin
		arst_n                    <= 1'b0;
		sample_ch.valid           <= 1'b0;
		sample_ch.sensor_error    <= 1'b0;
		sample_ch.pressure_sample <= '0;
		cfg_ch.valid              <= 1'b0;
		cfg_ch.index              <= mtwa_pkg::REG_WEIGHT_NEWEST;
		cfg_ch.data               <= '0;
		hold_requests   = 0;
		items_sent      = 0;
		weight_settings = 1;
		level           = mtwa_pkg::PRESS_W'(32'd16000);
		set_gaps(GAPS_NONE);
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: error before any sample, extremes, errors between samples
		offer_sample(1'b1, PRESS_MAX);
		offer_sample(1'b0, '0);
		repeat (6) offer_sample(1'b0, PRESS_MAX);
		offer_sample(1'b1, '0);
		repeat (3) offer_sample(1'b0, '0);
		offer_sample(1'b0, 21'h155555);
		offer_sample(1'b0, 21'h0AAAAA);
		offer_sample(1'b0, 21'h000001);
		offer_sample(1'b1, 21'h0AAAAA);
		offer_sample(1'b0, PRESS_MAX - 1);
		offer_sample(1'b0, 21'h100000);
		offer_sample(1'b0, PRESS_MAX);
		offer_sample(1'b1, PRESS_MAX);
		offer_sample(1'b0, 21'h0FFFFF);
		offer_sample(1'b0, 21'h000130);
		drain();

		// heaviest weights, no idling
		set_weights('1, '1, '1, '1);
		random_samples(90);
		drain();

		// weights summing to zero, sender idling
		set_weights('0, '0, '0, '0);
		set_gaps(GAPS_SENDER);
		random_samples(80);
		drain();

		// newest and oldest taps at opposite extremes, receiver stalling
		set_weights(8'd1, '0, '0, '1);
		set_gaps(GAPS_RECEIVER);
		random_samples(90);
		drain();

		// random weights, both sides idling
		set_weights(pick_weight(), pick_weight(), pick_weight(), pick_weight());
		set_gaps(GAPS_BOTH);
		random_samples(90);
		drain();

		// long output hold while samples keep coming
		set_weights('1, '0, '0, '0);
		set_gaps(GAPS_NONE);
		hold_requests++;
		random_samples(60);
		drain();

		// random weights, mixed idling, with a pause for a full drain midway
		set_weights(pick_weight(), pick_weight(), pick_weight(), pick_weight());
		set_gaps(GAPS_BOTH);
		random_samples(45);
		drain();
		set_gaps(GAPS_RECEIVER);
		random_samples(45);
		drain();

		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d sample items under %0d weight settings", items_sent,
			weight_settings);
		$display("%0d results checked, %0d long output holds", results_checked, long_holds);
		if (fail_count == 0) begin
			$display("PASS median_then_weighted_average_filter");
		end else begin
			$display("FAIL median_then_weighted_average_filter");
		end
		$finish;
	end

endmodule

FILE: median_then_weighted_average_filter.f
hw/rtl/mtwa_pkg.sv
hw/rtl/mtwa_ifs.sv
hw/rtl/median_then_weighted_average_filter.sv
tb/mtwa_result_checker.sv
tb/median_then_weighted_average_filter_test.sv
